[rtl/toy_register_memory_cpu_execute_assert.svh]
// Assertion macros used by the execute module.
`ifndef TOY_REGISTER_MEMORY_CPU_EXECUTE_ASSERT_SVH
`define TOY_REGISTER_MEMORY_CPU_EXECUTE_ASSERT_SVH

// Same-cycle implication.
`define TRMC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("trmc: same-cycle check failed");

// Next-cycle implication.
`define TRMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("trmc: next-cycle check failed");

`endif

[rtl/trmc_pkg.sv]
package trmc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PC_W   = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  localparam logic [PC_W-1:0] START_PC_RST = PC_W'(1);

  typedef enum logic [3:0] {
    MODE_MOV = 4'd0,
    MODE_ADD = 4'd1,
    MODE_SUB = 4'd2,
    MODE_MUL = 4'd3,
    MODE_DIV = 4'd4,
    MODE_CMP = 4'd5,
    MODE_JMP = 4'd6,
    MODE_JE  = 4'd7,
    MODE_JG  = 4'd8,
    MODE_JL  = 4'd9,
    MODE_NOP = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    SRC_LIT = 2'd0,
    SRC_REG = 2'd1,
    SRC_MEM = 2'd2
  } src_kind_e;

  typedef enum logic {
    CFG_START_PC = 1'b0,
    CFG_PROG_LEN = 1'b1
  } cfg_index_e;

  // Input tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic        target_known;
    logic [9:0]  jump_target;
    logic [30:0] literal_value;
    logic [4:0]  src_addr;
    logic [2:0]  src_reg;
    logic [4:0]  dst_addr;
    logic [2:0]  dst_reg;
    logic [3:0]  mode;
  } in_data_t;

  // Input tuser.
  typedef struct packed {
    logic [1:0] src_kind;
    logic       dst_is_mem;
  } in_user_t;

  typedef struct packed {
    in_user_t user;
    in_data_t data;
  } item_t;

  // Output tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic              fault;
    logic              halted;
    logic              less_flag;
    logic              greater_flag;
    logic              zero_flag;
    logic              write_valid;
    logic [WORD_W-1:0] write_value;
    logic [PC_W-1:0]   next_pc;
  } out_data_t;

  typedef struct packed {
    logic less;
    logic greater;
    logic zero;
  } flags_t;

endpackage

[rtl/toy_register_memory_cpu_execute.sv]
// Executes one decoded instruction per input item against six registers, a
// small data memory, the compare flags and the program counter, and returns
// one result item per input item. Registers and memory words share one
// single-port-read RAM, read once for the source and once for the
// destination; all arithmetic goes through one 33-bit adder. After reset the
// block clears that RAM, one entry a cycle over all MEM_WORDS + NUM_REGS
// entries, and takes no item meanwhile (configuration writes are taken). An
// item then passes through source read, destination read, operate and
// write-back; MUL and DIV add the shift-and-add multiply and the restoring
// divide running one bit a cycle on the shared adder; an item arriving while
// the counter is halted goes straight to write-back. The result sits in an
// output register, so the next item may be accepted before it is taken.
`include "toy_register_memory_cpu_execute_assert.svh"

module toy_register_memory_cpu_execute
  import trmc_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 32,
  parameter int unsigned NUM_REGS  = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // mode, dst_reg, dst_addr, src_reg, src_addr, literal_value, jump_target,
  // target_known, zero fill
  input  logic [63:0] s_axis_tdata_i,
  // dst_is_mem, src_kind
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // next_pc, write_value, write_valid, zero_flag, greater_flag, less_flag,
  // halted, fault
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned Depth = MEM_WORDS + NUM_REGS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SumW  = WORD_W + 1;
  localparam logic [AW-1:0]    LastAddr = AW'(Depth - 1);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(WORD_W - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_RSRC  = 10'b00_0000_0100,
    S_RDST  = 10'b00_0000_1000,
    S_OPER  = 10'b00_0001_0000,
    S_NEGB  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_MUL   = 10'b00_1000_0000,
    S_NEGQ  = 10'b01_0000_0000,
    S_WB    = 10'b10_0000_0000
  } state_e;

  function automatic logic [AW-1:0] mem_idx(input logic [4:0] a);
    return AW'(NUM_REGS) + AW'(a);
  endfunction

  function automatic logic reg_ok(input logic [2:0] r);
    return {2'b00, r} < 5'(NUM_REGS);
  endfunction

  function automatic logic mem_ok(input logic [4:0] a);
    return {6'b0, a} < 11'(MEM_WORDS);
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  item_t              item_q, item_d;
  logic               skip_q, skip_d;
  logic [WORD_W-1:0]  src_q, src_d;
  logic [WORD_W-1:0]  dst_q, dst_d;
  logic [WORD_W-1:0]  acc_q, acc_d;
  logic [WORD_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               sign_q, sign_d;
  logic [WORD_W-1:0]  res_q, res_d;
  logic               wr_q, wr_d;
  logic               fault_q, fault_d;
  flags_t             flags_q, flags_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               ovalid_q, ovalid_d;
  out_data_t          odata_q, odata_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [WORD_W-1:0]  add_a, add_b;
  logic               add_sub;
  logic [SumW-1:0]    add_sum;

  logic [AW-1:0]      src_index, dst_index;
  logic [WORD_W-1:0]  src_val, dst_val, rem_sh;
  logic               src_ok, dst_ok, arith, op_en, cmp_en, dst_lt;
  logic               take, wr_ok, out_free;
  logic [PC_W-1:0]    next_pc;
  mode_e              mode;

  trmc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign mode = mode_e'(item_q.data.mode);

  assign src_index = (item_q.user.src_kind == SRC_MEM) ? mem_idx(item_q.data.src_addr)
                                                       : AW'(item_q.data.src_reg);
  assign dst_index = item_q.user.dst_is_mem ? mem_idx(item_q.data.dst_addr)
                                            : AW'(item_q.data.dst_reg);

  assign src_ok = item_q.user.src_kind inside {SRC_LIT, SRC_REG, SRC_MEM};
  assign dst_ok = item_q.user.dst_is_mem ? (item_q.user.src_kind != SRC_MEM)
                                         : reg_ok(item_q.data.dst_reg);
  assign arith  = item_q.data.mode inside {MODE_MOV, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};
  assign op_en  = arith && dst_ok && src_ok;
  assign cmp_en = (mode == MODE_CMP) && !item_q.user.dst_is_mem &&
                  reg_ok(item_q.data.dst_reg) && src_ok;
  assign wr_ok  = !item_q.user.dst_is_mem || mem_ok(item_q.data.dst_addr);

  always_comb begin
    case (item_q.user.src_kind)
      SRC_LIT: src_val = {1'b0, item_q.data.literal_value};
      SRC_REG: src_val = reg_ok(item_q.data.src_reg) ? ram_rdata : '0;
      SRC_MEM: src_val = mem_ok(item_q.data.src_addr) ? ram_rdata : '0;
      default: src_val = '0;
    endcase
  end

  assign dst_val = (item_q.user.dst_is_mem && !mem_ok(item_q.data.dst_addr)) ? '0 : ram_rdata;
  assign rem_sh  = {acc_q[WORD_W-2:0], quo_q[WORD_W-1]};

  // Shared adder operand selection.
  always_comb begin
    add_a   = dst_val;
    add_b   = src_q;
    add_sub = 1'b1;
    case (state_q)
      S_OPER: begin
        if (mode == MODE_DIV) begin
          add_a = '0;
          add_b = dst_val;
        end else begin
          add_sub = (mode != MODE_ADD);
        end
      end
      S_NEGB: begin
        add_a = '0;
        add_b = src_q;
      end
      S_DIV: begin
        add_a = rem_sh;
        add_b = src_q;
      end
      S_MUL: begin
        add_a   = acc_q;
        add_b   = quo_q[0] ? dst_q : '0;
        add_sub = 1'b0;
      end
      S_NEGQ: begin
        add_a = '0;
        add_b = quo_q;
      end
      default: begin
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {WORD_W{add_sub}}} + SumW'(add_sub);

  assign dst_lt = (dst_val[WORD_W-1] ^ src_q[WORD_W-1]) ? dst_val[WORD_W-1]
                                                        : add_sum[WORD_W-1];

  always_comb begin
    case (mode)
      MODE_JMP: take = 1'b1;
      MODE_JE:  take = flags_q.zero;
      MODE_JG:  take = flags_q.greater;
      MODE_JL:  take = flags_q.less;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    if (skip_q) begin
      next_pc = pc_q;
    end else if (take && item_q.data.target_known) begin
      next_pc = item_q.data.jump_target;
    end else begin
      next_pc = pc_q + PC_W'(1);
    end
  end

  assign out_free = !ovalid_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    skip_d    = skip_q;
    src_d     = src_q;
    dst_d     = dst_q;
    acc_d     = acc_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    sign_d    = sign_q;
    res_d     = res_q;
    wr_d      = wr_q;
    fault_d   = fault_q;
    flags_d   = flags_q;
    pc_d      = pc_q;
    len_d     = len_q;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_waddr = dst_index;
    ram_wdata = res_q;
    ram_raddr = src_index;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          item_d.data = in_data_t'(s_axis_tdata_i);
          item_d.user = in_user_t'(s_axis_tuser_i);
          skip_d      = ({1'b0, pc_q} == len_q);
          wr_d        = 1'b0;
          fault_d     = 1'b0;
          state_d     = ({1'b0, pc_q} == len_q) ? S_WB : S_RSRC;
        end
      end
      S_RSRC: begin
        state_d = S_RDST;
      end
      S_RDST: begin
        ram_raddr = dst_index;
        src_d     = src_val;
        state_d   = S_OPER;
      end
      S_OPER: begin
        state_d = S_WB;
        if (cmp_en) begin
          flags_d.zero    = (add_sum[WORD_W-1:0] == '0);
          flags_d.greater = (add_sum[WORD_W-1:0] != '0) && !dst_lt;
          flags_d.less    = (add_sum[WORD_W-1:0] != '0) && dst_lt;
        end
        if (op_en) begin
          case (mode)
            MODE_MOV: begin
              res_d = src_q;
              wr_d  = 1'b1;
            end
            MODE_ADD, MODE_SUB: begin
              res_d = add_sum[WORD_W-1:0];
              wr_d  = 1'b1;
            end
            MODE_MUL: begin
              acc_d   = '0;
              dst_d   = dst_val;
              quo_d   = src_q;
              cnt_d   = '0;
              state_d = S_MUL;
            end
            MODE_DIV: begin
              if (src_q == '0) begin
                fault_d = 1'b1;
              end else begin
                quo_d   = dst_val[WORD_W-1] ? add_sum[WORD_W-1:0] : dst_val;
                sign_d  = dst_val[WORD_W-1] ^ src_q[WORD_W-1];
                state_d = S_NEGB;
              end
            end
            default: begin
              wr_d = 1'b0;
            end
          endcase
        end
      end
      S_NEGB: begin
        src_d   = src_q[WORD_W-1] ? add_sum[WORD_W-1:0] : src_q;
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (add_sum[WORD_W]) begin
          acc_d = add_sum[WORD_W-1:0];
          quo_d = {quo_q[WORD_W-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          quo_d = {quo_q[WORD_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LastStep) begin
          state_d = S_NEGQ;
        end
      end
      S_MUL: begin
        acc_d = add_sum[WORD_W-1:0];
        dst_d = {dst_q[WORD_W-2:0], 1'b0};
        quo_d = {1'b0, quo_q[WORD_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LastStep) begin
          res_d   = add_sum[WORD_W-1:0];
          wr_d    = 1'b1;
          state_d = S_WB;
        end
      end
      S_NEGQ: begin
        res_d   = sign_q ? add_sum[WORD_W-1:0] : quo_q;
        wr_d    = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          ram_we               = wr_q && wr_ok;
          pc_d                 = next_pc;
          ovalid_d             = 1'b1;
          odata_d.next_pc      = next_pc;
          odata_d.write_value  = (wr_q && wr_ok) ? res_q : '0;
          odata_d.write_valid  = wr_q && wr_ok;
          odata_d.zero_flag    = flags_q.zero;
          odata_d.greater_flag = flags_q.greater;
          odata_d.less_flag    = flags_q.less;
          odata_d.halted       = ({1'b0, next_pc} == len_q);
          odata_d.fault        = fault_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_START_PC: pc_d  = cfg_wdata_i[PC_W-1:0];
        CFG_PROG_LEN: len_d = cfg_wdata_i;
        default:      len_d = len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      skip_q   <= 1'b0;
      wr_q     <= 1'b0;
      fault_q  <= 1'b0;
      cnt_q    <= '0;
      flags_q  <= '0;
      pc_q     <= START_PC_RST;
      len_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      skip_q   <= skip_d;
      wr_q     <= wr_d;
      fault_q  <= fault_d;
      cnt_q    <= cnt_d;
      flags_q  <= flags_d;
      pc_q     <= pc_d;
      len_q    <= len_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    acc_q   <= acc_d;
    quo_q   <= quo_d;
    sign_q  <= sign_d;
    res_q   <= res_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  `TRMC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `TRMC_ASSERT_SAME(a_fault_no_write, clk_i, rst_ni, ovalid_q && odata_q.fault, !odata_q.write_valid && odata_q.write_value == '0)
  `TRMC_ASSERT_SAME(a_flags_exclusive, clk_i, rst_ni, 1'b1, $onehot0(flags_q))
  `TRMC_ASSERT_NEXT(a_div_runs_full, clk_i, rst_ni, state_q == S_DIV && cnt_q != LastStep, state_q == S_DIV)

endmodule

[rtl/trmc_ram.sv]
module trmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
